// ===== rtl/core/dhsm_pkg.sv =====
// ============================================================================
// Hit-to-strip mapper package
// Shared widths, register indexes, reset values and helper functions.
// ============================================================================
package dhsm_pkg;

    localparam int PITCH_SHIFT = 5;

    localparam int HIT_W     = 14;  // input coordinate width
    localparam int LEN_W     = 13;  // geometry register width
    localparam int LIM_W     = 8;   // group limit register width
    localparam int CRD_W     = 17;  // mirrored and shifted coordinate width
    localparam int LOC_W     = 16;  // module-shifted x width
    localparam int GSTRIP_W  = 9;
    localparam int LSTRIP_W  = 8;
    localparam int MOD_W     = 3;
    localparam int GRP_W     = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [CRD_W-1:0] t_coord;
    typedef logic signed [LOC_W-1:0] t_loc;
    typedef logic [MOD_W-1:0]        t_mod;
    typedef logic [GRP_W-1:0]        t_grp;
    typedef logic [LEN_W-1:0]        t_len;
    typedef logic [LIM_W-1:0]        t_lim;

    // Module codes
    localparam t_mod MOD_OUTSIDE   = 3'd0;
    localparam t_mod MOD_TOP_RIGHT = 3'd1;
    localparam t_mod MOD_TOP_LEFT  = 3'd2;
    localparam t_mod MOD_BOT_LEFT  = 3'd3;
    localparam t_mod MOD_BOT_RIGHT = 3'd4;

    // Strip group codes
    localparam t_grp GRP_ZERO = 2'd0;
    localparam t_grp GRP_ONE  = 2'd1;
    localparam t_grp GRP_TWO  = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LEN     = 3'd0,
        CFG_NIB_LEN      = 3'd1,
        CFG_OFFSET       = 3'd2,
        CFG_G0_CROSS     = 3'd3,
        CFG_G0_ALONG     = 3'd4,
        CFG_G1_CROSS     = 3'd5,
        CFG_G1_ALONG     = 3'd6
    } t_cfg_idx;

    localparam t_len RST_BASE_LEN = 13'd5370;
    localparam t_len RST_NIB_LEN  = 13'd1790;
    localparam t_len RST_OFFSET   = 13'd1016;
    localparam t_lim RST_G0_CROSS = 8'd55;
    localparam t_lim RST_G0_ALONG = 8'd150;
    localparam t_lim RST_G1_CROSS = 8'd110;
    localparam t_lim RST_G1_ALONG = 8'd95;

    // Pitch bias for truncation toward zero on negative values
    localparam t_loc PITCH_BIAS = t_loc'((1 << PITCH_SHIFT) - 1);

    // Coordinate divided by the pitch, truncated toward zero
    function automatic t_loc strip_of(input t_loc c);
        t_loc biased;
        biased = c[LOC_W-1] ? (c + PITCH_BIAS) : c;
        return biased >>> PITCH_SHIFT;
    endfunction

    // Strip group from a cross coordinate a and an along coordinate b
    function automatic t_grp group_of(input t_lim a, input t_lim b,
                                      input t_lim c0, input t_lim a0,
                                      input t_lim c1, input t_lim a1);
        t_grp g;
        if ((a < c0 && b < a0) || b >= a0) begin
            g = GRP_ZERO;
        end else if ((a < c1 && b < a1) || b >= a1) begin
            g = GRP_ONE;
        end else begin
            g = GRP_TWO;
        end
        return g;
    endfunction

endpackage

// ===== rtl/core/detector_hit_to_strip_mapper_top.sv =====
// ============================================================================
// Detector hit-to-strip mapper
// Maps a hit position onto one of four pentagon modules and its strips.
//
// Input channel (i_in_valid / o_in_stall): one hit (x, y) in signed 0.1 mm
// units per transfer. Output channel (o_out_valid / i_out_stall): one result
// per hit, with module index, global and local strip indices and two strip
// groups; a hit outside all modules reads zero in every strip field.
// Configuration channel (i_cfg_valid / o_cfg_ready, index and data): ready is
// always high and an unknown index is dropped. Write only while empty.
// Five register stages (input, inside tests, module select, strip divide,
// groups/output); the fully pipelined datapath sustains one hit per cycle
// while the receiver does not stall.
// Each stage holds while its successor is full and blocked; empty stages keep
// filling, so bubbles collapse. o_in_stall rises only when all five stages
// are full and the receiver stalls. Reset (synchronous, active low) clears
// all valid bits and loads the default register values.
// ============================================================================
module detector_hit_to_strip_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dhsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dhsm_pkg::LEN_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [dhsm_pkg::HIT_W-1:0]   i_hit_x,
    input  logic signed [dhsm_pkg::HIT_W-1:0]   i_hit_y,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dhsm_pkg::MOD_W-1:0]          o_module_index,
    output logic signed [dhsm_pkg::GSTRIP_W-1:0] o_global_strip_x,
    output logic signed [dhsm_pkg::GSTRIP_W-1:0] o_global_strip_y,
    output logic [dhsm_pkg::LSTRIP_W-1:0]       o_local_strip_x,
    output logic [dhsm_pkg::LSTRIP_W-1:0]       o_local_strip_y,
    output logic [dhsm_pkg::GRP_W-1:0]          o_horizontal_group,
    output logic [dhsm_pkg::GRP_W-1:0]          o_vertical_group
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    dhsm_pkg::t_len r_base_len;
    dhsm_pkg::t_len r_nib_len;
    dhsm_pkg::t_len r_offset;
    dhsm_pkg::t_lim r_g0_cross;
    dhsm_pkg::t_lim r_g0_along;
    dhsm_pkg::t_lim r_g1_cross;
    dhsm_pkg::t_lim r_g1_along;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= dhsm_pkg::RST_BASE_LEN;
            r_nib_len  <= dhsm_pkg::RST_NIB_LEN;
            r_offset   <= dhsm_pkg::RST_OFFSET;
            r_g0_cross <= dhsm_pkg::RST_G0_CROSS;
            r_g0_along <= dhsm_pkg::RST_G0_ALONG;
            r_g1_cross <= dhsm_pkg::RST_G1_CROSS;
            r_g1_along <= dhsm_pkg::RST_G1_ALONG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dhsm_pkg::t_cfg_idx'(i_cfg_index))
                dhsm_pkg::CFG_BASE_LEN: r_base_len <= i_cfg_data;
                dhsm_pkg::CFG_NIB_LEN:  r_nib_len  <= i_cfg_data;
                dhsm_pkg::CFG_OFFSET:   r_offset   <= i_cfg_data;
                dhsm_pkg::CFG_G0_CROSS: r_g0_cross <= i_cfg_data[dhsm_pkg::LIM_W-1:0];
                dhsm_pkg::CFG_G0_ALONG: r_g0_along <= i_cfg_data[dhsm_pkg::LIM_W-1:0];
                dhsm_pkg::CFG_G1_CROSS: r_g1_cross <= i_cfg_data[dhsm_pkg::LIM_W-1:0];
                dhsm_pkg::CFG_G1_ALONG: r_g1_along <= i_cfg_data[dhsm_pkg::LIM_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when its
    // successor advances.
    // ------------------------------------------------------------------
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !r_vld5 || !i_out_stall;
    assign adv4 = !r_vld4 || adv5;
    assign adv3 = !r_vld3 || adv4;
    assign adv2 = !r_vld2 || adv3;
    assign adv1 = !r_vld1 || adv2;

    assign o_in_stall  = !adv1;
    assign o_out_valid = r_vld5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (adv1) r_vld1 <= i_in_valid;
            if (adv2) r_vld2 <= r_vld1;
            if (adv3) r_vld3 <= r_vld2;
            if (adv4) r_vld4 <= r_vld3;
            if (adv5) r_vld5 <= r_vld4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the hit
    // ------------------------------------------------------------------
    logic signed [dhsm_pkg::HIT_W-1:0] r1_x, r1_y;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_x <= i_hit_x;
            r1_y <= i_hit_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: mirror and shift, then run the four inside tests
    // ------------------------------------------------------------------
    dhsm_pkg::t_coord x_c, y_c, nx_c, ny_c, u3_c, u4_c, off_c;
    logic             n2_in1, n2_in2, n2_in3, n2_in4;

    assign x_c   = dhsm_pkg::t_coord'(r1_x);
    assign y_c   = dhsm_pkg::t_coord'(r1_y);
    assign off_c = $signed({{(dhsm_pkg::CRD_W - dhsm_pkg::LEN_W){1'b0}}, r_offset});
    assign nx_c  = -x_c;
    assign ny_c  = -y_c;
    assign u3_c  = -x_c - off_c;
    assign u4_c  = x_c - off_c;

    dhsm_inside u_in_top_right (
        .i_u(x_c),  .i_v(y_c),  .i_base(r_base_len), .i_nib(r_nib_len), .o_inside(n2_in1)
    );
    dhsm_inside u_in_top_left (
        .i_u(nx_c), .i_v(y_c),  .i_base(r_base_len), .i_nib(r_nib_len), .o_inside(n2_in2)
    );
    dhsm_inside u_in_bot_left (
        .i_u(u3_c), .i_v(ny_c), .i_base(r_base_len), .i_nib(r_nib_len), .o_inside(n2_in3)
    );
    dhsm_inside u_in_bot_right (
        .i_u(u4_c), .i_v(ny_c), .i_base(r_base_len), .i_nib(r_nib_len), .o_inside(n2_in4)
    );

    logic signed [dhsm_pkg::HIT_W-1:0] r2_x, r2_y;
    logic                              r2_in1, r2_in2, r2_in3, r2_in4;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_in1 <= n2_in1;
            r2_in2 <= n2_in2;
            r2_in3 <= n2_in3;
            r2_in4 <= n2_in4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pick the first matching module, remove its x shift
    // ------------------------------------------------------------------
    dhsm_pkg::t_mod n3_mod;
    dhsm_pkg::t_loc n3_xl;
    dhsm_pkg::t_loc x2_l, off_l;

    assign x2_l  = dhsm_pkg::t_loc'(r2_x);
    assign off_l = $signed({{(dhsm_pkg::LOC_W - dhsm_pkg::LEN_W){1'b0}}, r_offset});

    always_comb begin
        n3_xl = x2_l;
        if (r2_in1) begin
            n3_mod = dhsm_pkg::MOD_TOP_RIGHT;
        end else if (r2_in2) begin
            n3_mod = dhsm_pkg::MOD_TOP_LEFT;
        end else if (r2_in3) begin
            n3_mod = dhsm_pkg::MOD_BOT_LEFT;
            n3_xl  = x2_l + off_l;
        end else if (r2_in4) begin
            n3_mod = dhsm_pkg::MOD_BOT_RIGHT;
            n3_xl  = x2_l - off_l;
        end else begin
            n3_mod = dhsm_pkg::MOD_OUTSIDE;
        end
    end

    dhsm_pkg::t_mod                    r3_mod;
    dhsm_pkg::t_loc                    r3_xl;
    logic signed [dhsm_pkg::HIT_W-1:0] r3_x, r3_y;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_mod <= n3_mod;
            r3_xl  <= n3_xl;
            r3_x   <= r2_x;
            r3_y   <= r2_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: divide by the pitch and take magnitudes
    // ------------------------------------------------------------------
    dhsm_pkg::t_loc gx_l, gy_l, lx_l;
    dhsm_pkg::t_loc lx_abs, ly_abs;

    assign gx_l   = dhsm_pkg::strip_of(dhsm_pkg::t_loc'(r3_x));
    assign gy_l   = dhsm_pkg::strip_of(dhsm_pkg::t_loc'(r3_y));
    assign lx_l   = dhsm_pkg::strip_of(r3_xl);
    assign lx_abs = lx_l[dhsm_pkg::LOC_W-1] ? -lx_l : lx_l;
    assign ly_abs = gy_l[dhsm_pkg::LOC_W-1] ? -gy_l : gy_l;

    dhsm_pkg::t_mod                       r4_mod;
    logic signed [dhsm_pkg::GSTRIP_W-1:0] r4_gx, r4_gy;
    logic [dhsm_pkg::LSTRIP_W-1:0]        r4_lx, r4_ly;

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_mod <= r3_mod;
            r4_gx  <= gx_l[dhsm_pkg::GSTRIP_W-1:0];
            r4_gy  <= gy_l[dhsm_pkg::GSTRIP_W-1:0];
            r4_lx  <= lx_abs[dhsm_pkg::LSTRIP_W-1:0];
            r4_ly  <= ly_abs[dhsm_pkg::LSTRIP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: strip groups, zero everything for an outside hit
    // ------------------------------------------------------------------
    logic           hit_in;
    dhsm_pkg::t_grp n5_hgrp, n5_vgrp;

    assign hit_in  = r4_mod != dhsm_pkg::MOD_OUTSIDE;
    assign n5_hgrp = dhsm_pkg::group_of(r4_lx, r4_ly, r_g0_cross, r_g0_along,
                                        r_g1_cross, r_g1_along);
    assign n5_vgrp = dhsm_pkg::group_of(r4_ly, r4_lx, r_g0_cross, r_g0_along,
                                        r_g1_cross, r_g1_along);

    dhsm_pkg::t_mod                       r5_mod;
    logic signed [dhsm_pkg::GSTRIP_W-1:0] r5_gx, r5_gy;
    logic [dhsm_pkg::LSTRIP_W-1:0]        r5_lx, r5_ly;
    dhsm_pkg::t_grp                       r5_hgrp, r5_vgrp;

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r5_mod  <= r4_mod;
            r5_gx   <= hit_in ? r4_gx   : '0;
            r5_gy   <= hit_in ? r4_gy   : '0;
            r5_lx   <= hit_in ? r4_lx   : '0;
            r5_ly   <= hit_in ? r4_ly   : '0;
            r5_hgrp <= hit_in ? n5_hgrp : dhsm_pkg::GRP_ZERO;
            r5_vgrp <= hit_in ? n5_vgrp : dhsm_pkg::GRP_ZERO;
        end
    end

    assign o_module_index     = r5_mod;
    assign o_global_strip_x   = r5_gx;
    assign o_global_strip_y   = r5_gy;
    assign o_local_strip_x    = r5_lx;
    assign o_local_strip_y    = r5_ly;
    assign o_horizontal_group = r5_hgrp;
    assign o_vertical_group   = r5_vgrp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_outside_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_module_index == dhsm_pkg::MOD_OUTSIDE) |->
        (o_global_strip_x == '0 && o_global_strip_y == '0 &&
         o_local_strip_x == '0 && o_local_strip_y == '0 &&
         o_horizontal_group == dhsm_pkg::GRP_ZERO &&
         o_vertical_group == dhsm_pkg::GRP_ZERO))
        else $error("outside hit with nonzero strip fields");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_vld1 && r_vld2 && r_vld3 && r_vld4 && r_vld5 && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_group_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_horizontal_group <= dhsm_pkg::GRP_TWO &&
                         o_vertical_group <= dhsm_pkg::GRP_TWO &&
                         o_module_index <= dhsm_pkg::MOD_BOT_RIGHT))
        else $error("illegal module or group code");

endmodule

// ===== rtl/core/dhsm_inside.sv =====
// ============================================================================
// Pentagon inside test
// Strict box and diagonal-edge checks of one module on (u, v) coordinates.
// ============================================================================
module dhsm_inside (
    input  dhsm_pkg::t_coord i_u,
    input  dhsm_pkg::t_coord i_v,
    input  dhsm_pkg::t_len   i_base,
    input  dhsm_pkg::t_len   i_nib,
    output logic             o_inside
);

    dhsm_pkg::t_coord                 base_s;
    dhsm_pkg::t_coord                 nib_s;
    logic signed [dhsm_pkg::CRD_W:0]  sum_uv;
    logic signed [dhsm_pkg::CRD_W:0]  sum_bn;
    logic                             pos;
    logic                             u_lt_nib;
    logic                             v_lt_nib;
    logic                             u_lt_base;
    logic                             v_lt_base;

    assign base_s = $signed({{(dhsm_pkg::CRD_W - dhsm_pkg::LEN_W){1'b0}}, i_base});
    assign nib_s  = $signed({{(dhsm_pkg::CRD_W - dhsm_pkg::LEN_W){1'b0}}, i_nib});
    assign sum_uv = {i_u[dhsm_pkg::CRD_W-1], i_u} + {i_v[dhsm_pkg::CRD_W-1], i_v};
    assign sum_bn = {base_s[dhsm_pkg::CRD_W-1], base_s} + {nib_s[dhsm_pkg::CRD_W-1], nib_s};

    assign pos       = (i_u > dhsm_pkg::t_coord'(0)) && (i_v > dhsm_pkg::t_coord'(0));
    assign u_lt_nib  = i_u < nib_s;
    assign v_lt_nib  = i_v < nib_s;
    assign u_lt_base = i_u < base_s;
    assign v_lt_base = i_v < base_s;

    // Square minus the cut corner
    assign o_inside = pos && ((u_lt_nib && v_lt_base) || (u_lt_base && v_lt_nib) ||
                              (u_lt_base && v_lt_base && (sum_uv < sum_bn)));

endmodule
